// ----- sv/otms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otms_pkg
// Shared types, register indexes and fixed-point constants of the stereo
// overdrive core.
// ----------------------------------------------------------------------------
package otms_pkg;

	// Default sample width and the fixed channel count (left and right).
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int CHANNELS        = 2;
	localparam int CH_W            = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_BYPASS       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_RANGE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_KNOB   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOOST_HELD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_COEFF   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LEVEL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX      = 3'd6;

	// Drive range codes; the unused code behaves as the high range.
	localparam logic [1:0] RANGE_LOW  = 2'd0;
	localparam logic [1:0] RANGE_MID  = 2'd1;
	localparam logic [1:0] RANGE_HIGH = 2'd2;

	localparam int GAIN_LO [3] = '{1, 1, 4};
	localparam int GAIN_HI [3] = '{8, 24, 80};

	// Internal Q23 datapath widths.
	localparam int GAIN_W  = 24;
	localparam int COEF_W  = 17;
	localparam int Y_W     = 26;
	localparam int Y2_W    = 29;
	localparam int DEN_W   = 30;
	localparam int QUO_W   = 24;
	localparam int WETQ_W  = QUO_W + 1;
	localparam int ST_W    = 32;
	localparam int MUL_B_W = 26;

	// Divider: two quotient bits per step.
	localparam int DIV_BITS  = 2;
	localparam int DIV_STEPS = QUO_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [COEF_W-1:0] TONE_ONE = 17'd65536;
	localparam logic [15:0]       DC_COEF  = 16'd16777;
	localparam logic [DEN_W-1:0]  K27_Q23  = DEN_W'(27) << 23;
	localparam logic signed [Y_W-1:0] CLIP_LIM = Y_W'(3) <<< 23;

	typedef logic [GAIN_W-1:0] gain_t;

	// Drive gain in unsigned Q8.16: range minimum plus knob times span,
	// tripled while boost is held.
	function automatic gain_t drive_gain(input logic [1:0] range, input logic [15:0] knob,
			input logic boost);
		int unsigned ridx;
		logic [GAIN_W-1:0] base;
		logic [6:0]        span;
		logic [GAIN_W-1:0] g;
		ridx = (range > RANGE_HIGH) ? 2 : int'(range);
		base = GAIN_W'(GAIN_LO[ridx]) << 16;
		span = 7'(GAIN_HI[ridx] - GAIN_LO[ridx]);
		g = base + GAIN_W'(knob) * GAIN_W'(span);
		if (boost) begin
			g = g + (g << 1);
		end
		return g;
	endfunction

endpackage

// ----- sv/overdrive_tone_mix_stereo_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overdrive_tone_mix_stereo_core
// Stereo overdrive: drive gain, cubic soft clip, tone lowpass, DC removal,
// output level and dry/wet blend, computed on one shared multiplier.
// ----------------------------------------------------------------------------
// A frame (one left and one right sample) is taken on the input request
// handshake and its result leaves on the output request handshake. The two
// channels are processed one after the other by a single registered
// multiplier under a small sequencer, and the soft-clip quotient comes from
// a restoring divider that retires two bits per cycle. A processed frame goes
// from acceptance through forming the drive gain, then through each channel
// in turn (15 multiplier and bookkeeping steps plus 12 divider steps), then
// hands the result to the output register and returns to idle. In bypass
// the gain step passes the frame straight to the output hand-off and the
// filter states are left untouched. The finished frame sits in an output
// register, so a new frame is accepted while the previous result still waits
// to be taken. Configuration registers are written through a simple write
// port and should only be changed while no frame is in flight.
module overdrive_tone_mix_stereo_core #(
	parameter int SAMPLE_BITS = otms_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [otms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [otms_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     left_in,
	input  logic signed [SAMPLE_BITS-1:0]     right_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SAMPLE_BITS-1:0]     left_out,
	output logic signed [SAMPLE_BITS-1:0]     right_out
);
	import otms_pkg::*;

	// Fraction bits of the sample format and the derived shifts.
	localparam int FRAC   = SAMPLE_BITS - 1;
	localparam int DRV_SH = FRAC + 16 - 23;
	localparam int WF_UP  = (FRAC >= 23) ? FRAC - 23 : 0;
	localparam int WF_DN  = (FRAC < 23) ? 23 - FRAC : 1;
	localparam int WF_W   = 26 + WF_UP;
	// Operand A must hold the widest difference, the final wf minus x.
	localparam int A_W    = ((WF_W > 33) ? WF_W : 33) + 2;
	localparam int P_W    = A_W + MUL_B_W;

	localparam logic signed [P_W+1:0] SAT_HI = (P_W+2)'((64'sd1 <<< FRAC) - 64'sd1);
	localparam logic signed [P_W+1:0] SAT_LO = (P_W+2)'(-(64'sd1 <<< FRAC));

	// Sequencer states.
	localparam int SQ_W = 5;
	localparam logic [SQ_W-1:0] ST_IDLE  = 5'd0;
	localparam logic [SQ_W-1:0] ST_GAIN  = 5'd1;
	localparam logic [SQ_W-1:0] ST_DRIVE = 5'd2;
	localparam logic [SQ_W-1:0] ST_CLAMP = 5'd3;
	localparam logic [SQ_W-1:0] ST_SQ    = 5'd4;
	localparam logic [SQ_W-1:0] ST_Y2    = 5'd5;
	localparam logic [SQ_W-1:0] ST_NUM   = 5'd6;
	localparam logic [SQ_W-1:0] ST_DSET  = 5'd7;
	localparam logic [SQ_W-1:0] ST_DIV   = 5'd8;
	localparam logic [SQ_W-1:0] ST_WET   = 5'd9;
	localparam logic [SQ_W-1:0] ST_TMUL  = 5'd10;
	localparam logic [SQ_W-1:0] ST_TACC  = 5'd11;
	localparam logic [SQ_W-1:0] ST_DMUL  = 5'd12;
	localparam logic [SQ_W-1:0] ST_DACC  = 5'd13;
	localparam logic [SQ_W-1:0] ST_LMUL  = 5'd14;
	localparam logic [SQ_W-1:0] ST_WF    = 5'd15;
	localparam logic [SQ_W-1:0] ST_MMUL  = 5'd16;
	localparam logic [SQ_W-1:0] ST_MACC  = 5'd17;
	localparam logic [SQ_W-1:0] ST_DONE  = 5'd18;

	// Configuration registers.
	logic              bypass_q;
	logic [1:0]        range_q;
	logic [15:0]       knob_q;
	logic              boost_q;
	logic [COEF_W-1:0] tcoef_q;
	logic [15:0]       level_q;
	logic [15:0]       mix_q;

	// Sequencer and datapath registers.
	logic [SQ_W-1:0]                  state_q;
	logic [CH_W-1:0]                  ch_q;
	logic [DIV_CNT_W-1:0]             cnt_q;
	gain_t                            gain_q;
	logic signed [SAMPLE_BITS-1:0]    x_q   [CHANNELS];
	logic signed [SAMPLE_BITS-1:0]    res_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0]    out_q [CHANNELS];
	logic                             out_valid_q;
	logic signed [ST_W-1:0]           tone_q [CHANNELS];
	logic signed [ST_W-1:0]           dc_q   [CHANNELS];
	logic signed [P_W-1:0]            prod_q;
	logic signed [Y_W-1:0]            y_q;
	logic [Y2_W-1:0]                  y2_q;
	logic [DEN_W-1:0]                 den_q;
	logic [DEN_W-1:0]                 rem_q;
	logic [QUO_W-1:0]                 dq_q;
	logic                             neg_q;
	logic signed [WETQ_W-1:0]         wet_q;
	logic signed [A_W-1:0]            wf_q;

	// Combinational signals.
	logic signed [A_W-1:0]      mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [P_W-1:0]      mul_p;
	logic signed [SAMPLE_BITS-1:0] x_cur;
	logic signed [ST_W-1:0]     t_cur;
	logic signed [ST_W-1:0]     d_cur;
	logic [COEF_W-1:0]          tone_c;
	logic signed [P_W:0]        drv_w;
	logic signed [Y_W-1:0]      y_clamp;
	logic signed [P_W:0]        y2_w;
	logic signed [P_W:0]        r16_w;
	logic signed [P_W:0]        r24_w;
	logic signed [P_W:0]        wf_w;
	logic signed [P_W+1:0]      mix_o;
	logic signed [SAMPLE_BITS-1:0] sat_o;
	logic [P_W-1:0]             mag;
	logic [DEN_W-1:0]           rem_n;
	logic [QUO_W-1:0]           dq_n;
	logic                       last_ch;
	logic                       out_load;

	// Round to nearest with ties toward +infinity, by s bits.
	function automatic logic signed [P_W:0] rnd_shift(input logic signed [P_W-1:0] v,
			input int unsigned s);
		logic signed [P_W:0] ext;
		logic signed [P_W:0] half;
		ext = (P_W+1)'(v);
		half = '0;
		half[s-1] = 1'b1;
		return (ext + half) >>> s;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign left_out  = out_q[0];
	assign right_out = out_q[1];

	assign x_cur   = x_q[ch_q];
	assign t_cur   = tone_q[ch_q];
	assign d_cur   = dc_q[ch_q];
	assign tone_c  = (tcoef_q > TONE_ONE) ? TONE_ONE : tcoef_q;
	assign last_ch = (ch_q == CH_W'(CHANNELS - 1));
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// The shared multiplier; its product is registered every cycle.
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DRIVE: begin
				mul_a = A_W'(x_cur);
				mul_b = MUL_B_W'(signed'({1'b0, gain_q}));
			end
			ST_SQ: begin
				mul_a = A_W'(y_q);
				mul_b = y_q;
			end
			ST_NUM: begin
				mul_a = A_W'(signed'({1'b0, K27_Q23 + DEN_W'(y2_q)}));
				mul_b = y_q;
			end
			ST_TMUL: begin
				mul_a = A_W'(wet_q) - A_W'(t_cur);
				mul_b = MUL_B_W'(signed'({1'b0, tone_c}));
			end
			ST_DMUL: begin
				mul_a = A_W'(t_cur) - A_W'(d_cur);
				mul_b = MUL_B_W'(signed'({1'b0, DC_COEF}));
			end
			ST_LMUL: begin
				mul_a = A_W'(t_cur) - A_W'(d_cur);
				mul_b = MUL_B_W'(signed'({1'b0, level_q}));
			end
			ST_MMUL: begin
				mul_a = wf_q - A_W'(x_cur);
				mul_b = MUL_B_W'(signed'({1'b0, mix_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Post-multiply rounding, clamping and saturation.
	always_comb begin
		drv_w = rnd_shift(prod_q, DRV_SH);
		if (drv_w > (P_W+1)'(CLIP_LIM)) begin
			y_clamp = CLIP_LIM;
		end else if (drv_w < -(P_W+1)'(CLIP_LIM)) begin
			y_clamp = -CLIP_LIM;
		end else begin
			y_clamp = drv_w[Y_W-1:0];
		end
		y2_w  = rnd_shift(prod_q, 23);
		r16_w = rnd_shift(prod_q, 16);
		r24_w = rnd_shift(prod_q, 24);
		if (FRAC >= 23) begin
			wf_w = r16_w <<< WF_UP;
		end else begin
			wf_w = rnd_shift(r16_w[P_W-1:0], WF_DN);
		end
		mix_o = (P_W+2)'(x_cur) + (P_W+2)'(r16_w);
		if (mix_o > SAT_HI) begin
			sat_o = SAMPLE_BITS'(SAT_HI);
		end else if (mix_o < SAT_LO) begin
			sat_o = SAMPLE_BITS'(SAT_LO);
		end else begin
			sat_o = mix_o[SAMPLE_BITS-1:0];
		end
		mag = prod_q[P_W-1] ? P_W'(-prod_q) : P_W'(prod_q);
	end

	// Two restoring divide steps per cycle.
	always_comb begin
		logic [DEN_W:0] trial;
		rem_n = rem_q;
		dq_n  = dq_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {rem_n, dq_n[QUO_W-1]};
			dq_n  = dq_n << 1;
			if (trial >= {1'b0, den_q}) begin
				trial    = trial - {1'b0, den_q};
				dq_n[0]  = 1'b1;
			end
			rem_n = trial[DEN_W-1:0];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b1;
			range_q  <= RANGE_LOW;
			knob_q   <= '0;
			boost_q  <= 1'b0;
			tcoef_q  <= TONE_ONE;
			level_q  <= 16'hFFFF;
			mix_q    <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BYPASS:       bypass_q <= cfg_data[0];
				REG_DRIVE_RANGE:  range_q  <= cfg_data[1:0];
				REG_DRIVE_KNOB:   knob_q   <= cfg_data[15:0];
				REG_BOOST_HELD:   boost_q  <= cfg_data[0];
				REG_TONE_COEFF:   tcoef_q  <= cfg_data[COEF_W-1:0];
				REG_OUTPUT_LEVEL: level_q  <= cfg_data[15:0];
				REG_WET_MIX:      mix_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				tone_q[i] <= '0;
				dc_q[i]   <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					ch_q    <= '0;
					state_q <= bypass_q ? ST_DONE : ST_DRIVE;
				end
				ST_DRIVE: state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_SQ;
				ST_SQ:    state_q <= ST_Y2;
				ST_Y2:    state_q <= ST_NUM;
				ST_NUM:   state_q <= ST_DSET;
				ST_DSET: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_WET;
					end
				end
				ST_WET:  state_q <= ST_TMUL;
				ST_TMUL: state_q <= ST_TACC;
				ST_TACC: begin
					tone_q[ch_q] <= t_cur + r16_w[ST_W-1:0];
					state_q      <= ST_DMUL;
				end
				ST_DMUL: state_q <= ST_DACC;
				ST_DACC: begin
					dc_q[ch_q] <= d_cur + r24_w[ST_W-1:0];
					state_q    <= ST_LMUL;
				end
				ST_LMUL: state_q <= ST_WF;
				ST_WF:   state_q <= ST_MMUL;
				ST_MMUL: state_q <= ST_MACC;
				ST_MACC: begin
					if (last_ch) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_DRIVE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath payload registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_valid && in_ready) begin
			x_q[0] <= left_in;
			x_q[1] <= right_in;
		end
		if (out_load) begin
			out_q <= res_q;
		end
		case (state_q)
			ST_GAIN: begin
				gain_q <= drive_gain(range_q, knob_q, boost_q);
				if (bypass_q) begin
					res_q <= x_q;
				end
			end
			ST_CLAMP: y_q  <= y_clamp;
			ST_Y2:    y2_q <= y2_w[Y2_W-1:0];
			ST_NUM:   den_q <= K27_Q23 + {y2_q[DEN_W-4:0], 3'b000} + DEN_W'(y2_q);
			ST_DSET: begin
				neg_q <= prod_q[P_W-1];
				rem_q <= mag[QUO_W+DEN_W-1:QUO_W];
				dq_q  <= mag[QUO_W-1:0];
			end
			ST_DIV: begin
				rem_q <= rem_n;
				dq_q  <= dq_n;
			end
			ST_WET: wet_q <= neg_q ? -signed'({1'b0, dq_q}) : signed'({1'b0, dq_q});
			ST_WF:  wf_q  <= wf_w[A_W-1:0];
			ST_MACC: res_q[ch_q] <= sat_o;
			default: begin
			end
		endcase
	end

endmodule

// ----- bench/tb_overdrive_tone_mix_stereo_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overdrive_tone_mix_stereo_core
// Self-checking bench for the stereo overdrive core. Frames are offered on the
// input request handshake with random gaps, and results are taken with random
// stalls. Each result is compared with a bit-exact software copy of the drive,
// soft clip, tone lowpass, DC removal, level and dry/wet chain.
// ----------------------------------------------------------------------------
module tb_overdrive_tone_mix_stereo_core;

	localparam int SB = 24;

	// Index seven selects no register; writes to it must change nothing.
	localparam logic [otms_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam longint Q23_ONE    = longint'(1) << 23;
	localparam longint TONE_UNITY = 65536;
	localparam longint DC_TRACK   = 16777;

	localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

	localparam int SETTINGS_RUN       = 12;
	localparam int FRAMES_PER_SETTING = 102;
	localparam int WAIT_MAX           = 12;
	localparam int HOLD_OFF_CYCLES    = 400;
	localparam int TAIL_CYCLES        = 80;
	localparam int REPORT_CAP         = 100;

	typedef struct packed {
		logic signed [SB-1:0] left;
		logic signed [SB-1:0] right;
	} frame_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [otms_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [otms_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic signed [SB-1:0]            left_in;
	logic signed [SB-1:0]            right_in;
	logic                            out_valid;
	logic                            out_ready;
	logic signed [SB-1:0]            left_out;
	logic signed [SB-1:0]            right_out;

	// Shadow copy of the configuration registers, as the core should hold them.
	logic        m_bypass;
	logic [1:0]  m_range;
	logic [15:0] m_knob;
	logic        m_boost;
	logic [16:0] m_tone;
	logic [15:0] m_level;
	logic [15:0] m_mix;

	// Per-channel filter memories of the predictor (tone lowpass, DC tracker).
	int tone_mem [2];
	int dc_mem [2];

	// Processed frames that the core still owes us, oldest first.
	frame_t expected_frames [$];

	int frames_sent;
	int frames_checked;
	int failures;
	int settings_run;

	// Largest random wait per side; zero gives a stretch with no idling.
	int in_gap_max;
	int out_gap_max;

	// Set by the back-pressure test; the result side consumes it.
	int hold_off_request;

	overdrive_tone_mix_stereo_core #(
		.SAMPLE_BITS(SB)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Divide by 2^s, rounding to nearest with ties toward plus infinity. The
	// arithmetic shift of a signed value already floors.
	function automatic longint shift_round(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// One channel through the full wet chain, updating that channel's filters.
	function automatic logic signed [SB-1:0] shape_sample(input int ch,
			input logic signed [SB-1:0] sample);
		longint x;
		longint g_lo;
		longint g_hi;
		longint gain;
		longint coef;
		longint y;
		longint y2;
		longint clip;
		longint t;
		longint d;
		longint wet;
		longint o;
		x = longint'(sample);
		case (m_range)
			otms_pkg::RANGE_LOW: begin
				g_lo = 1;
				g_hi = 8;
			end
			otms_pkg::RANGE_MID: begin
				g_lo = 1;
				g_hi = 24;
			end
			// The unused range code falls back to the high range.
			default: begin
				g_lo = 4;
				g_hi = 80;
			end
		endcase
		gain = g_lo * 65536 + longint'(m_knob) * (g_hi - g_lo);
		if (m_boost) begin
			gain = gain * 3;
		end
		// A tone coefficient beyond unity is treated as unity.
		coef = (longint'(m_tone) > TONE_UNITY) ? TONE_UNITY : longint'(m_tone);

		// Drive, then clamp to +-3.0 where the cubic curve reaches +-1.
		y = shift_round(x * gain, 16);
		if (y > 3 * Q23_ONE) begin
			y = 3 * Q23_ONE;
		end
		if (y < -3 * Q23_ONE) begin
			y = -3 * Q23_ONE;
		end
		y2 = shift_round(y * y, 23);
		clip = (y * (27 * Q23_ONE + y2)) / (27 * Q23_ONE + 9 * y2);

		// The stored states are 32 bits wide, but this frame keeps full width.
		t = longint'(tone_mem[ch]);
		t = t + shift_round(coef * (clip - t), 16);
		tone_mem[ch] = int'(t);
		d = longint'(dc_mem[ch]);
		d = d + shift_round(DC_TRACK * (t - d), 24);
		dc_mem[ch] = int'(d);

		wet = shift_round((t - d) * longint'(m_level), 16);
		o = x + shift_round(longint'(m_mix) * (wet - x), 16);
		if (o > Q23_ONE - 1) begin
			o = Q23_ONE - 1;
		end
		if (o < -Q23_ONE) begin
			o = -Q23_ONE;
		end
		return SB'(o);
	endfunction

	// Work out the frame the core must return for an accepted request.
	task automatic forecast_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		frame_t f;
		if (m_bypass) begin
			f.left = l;
			f.right = r;
		end else begin
			f.left = shape_sample(0, l);
			f.right = shape_sample(1, r);
		end
		expected_frames.push_back(f);
	endtask

	function automatic int draw_wait(input int max_wait);
		if (max_wait == 0 || $urandom_range(0, 2) == 0) begin
			return 0;
		end
		return int'($urandom_range(0, max_wait));
	endfunction

	function automatic logic signed [SB-1:0] draw_sample();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return SAMPLE_MAX;
					1: return SAMPLE_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return SB'(int'($urandom_range(0, 8191)) - 4096);
			default: return SB'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] draw_fraction();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [16:0] draw_tone();
		case ($urandom_range(0, 5))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'h1FFFF;
			3: return 17'($urandom_range(0, 2047));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	// One register write. The shadow copy keeps only the bits the register
	// has, so junk in the upper data bits is checked for free.
	task automatic set_reg(input logic [otms_pkg::CFG_IDX_W-1:0] idx,
			input logic [otms_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			otms_pkg::REG_BYPASS:       m_bypass = value[0];
			otms_pkg::REG_DRIVE_RANGE:  m_range = value[1:0];
			otms_pkg::REG_DRIVE_KNOB:   m_knob = value[15:0];
			otms_pkg::REG_BOOST_HELD:   m_boost = value[0];
			otms_pkg::REG_TONE_COEFF:   m_tone = value[16:0];
			otms_pkg::REG_OUTPUT_LEVEL: m_level = value[15:0];
			otms_pkg::REG_WET_MIX:      m_mix = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one frame and hold it until the core takes it. Valid stays high
	// on return so that a back-to-back frame needs no second assignment.
	task automatic send_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		int gap;
		gap = draw_wait(in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		do @(posedge clk); while (in_ready !== 1'b1);
		forecast_frame(l, r);
		frames_sent++;
	endtask

	// Stop offering and wait until every owed result has come back, so the
	// core is idle and registers may change.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic check_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		frame_t want;
		if (expected_frames.size() == 0) begin
			failures++;
			if (failures <= REPORT_CAP) begin
				$display("%0t: result with nothing expected, expected none, got %0d / %0d",
					$time, l, r);
			end
			return;
		end
		want = expected_frames.pop_front();
		frames_checked++;
		if (l !== want.left) begin
			failures++;
			if (failures <= REPORT_CAP) begin
				$display("%0t: left_out mismatch, expected %0d, got %0d", $time, want.left, l);
			end
		end
		if (r !== want.right) begin
			failures++;
			if (failures <= REPORT_CAP) begin
				$display("%0t: right_out mismatch, expected %0d, got %0d", $time, want.right, r);
			end
		end
		if (failures > REPORT_CAP && failures - REPORT_CAP <= 2 && (l !== want.left ||
				r !== want.right)) begin
			$display("%0t: further mismatch reports suppressed", $time);
		end
	endtask

	// Out of reset the core is in bypass: samples must come back untouched.
	task automatic test_bypass_after_reset();
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		send_frame(SAMPLE_MIN, SAMPLE_MAX);
		send_frame('0, '1);
		drain();
	endtask

	// Leave bypass and run with every other register still at its reset value.
	task automatic test_reset_defaults();
		set_reg(otms_pkg::REG_BYPASS, 17'd0);
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		send_frame('0, '0);
		send_frame(SB'(1), '1);
		drain();
	endtask

	// Maximum gain through the unused range code with boost, and a tone
	// coefficient beyond unity. Everything lands deep in the clip.
	task automatic test_hard_drive();
		set_reg(otms_pkg::REG_DRIVE_RANGE, 17'd3);
		set_reg(otms_pkg::REG_DRIVE_KNOB, 17'hFFFF);
		set_reg(otms_pkg::REG_BOOST_HELD, 17'd1);
		set_reg(otms_pkg::REG_TONE_COEFF, 17'h1FFFF);
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		send_frame(SB'(24'h400000), SB'(24'hC00000));
		send_frame(SAMPLE_MIN, SAMPLE_MAX);
		drain();
	endtask

	// Lowest gain, frozen tone filter, zero level and an all-dry mix: the
	// output must equal the input while the DC tracker still moves.
	task automatic test_dry_frozen_tone();
		set_reg(otms_pkg::REG_DRIVE_RANGE, 17'(otms_pkg::RANGE_LOW));
		set_reg(otms_pkg::REG_DRIVE_KNOB, 17'd0);
		set_reg(otms_pkg::REG_BOOST_HELD, 17'd0);
		set_reg(otms_pkg::REG_TONE_COEFF, 17'd0);
		set_reg(otms_pkg::REG_OUTPUT_LEVEL, 17'd0);
		set_reg(otms_pkg::REG_WET_MIX, 17'd0);
		send_frame(SB'(123456), SB'(-654321));
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		drain();
	endtask

	// A bypass frame in the middle of processing must not disturb the filter
	// memories. The spare index is written too, and the bypass register gets
	// junk in its upper bits with bit zero clear.
	task automatic test_bypass_keeps_state();
		set_reg(otms_pkg::REG_BYPASS, 17'd1);
		send_frame(SAMPLE_MAX, SB'(5));
		drain();
		set_reg(REG_SPARE, 17'($urandom));
		set_reg(otms_pkg::REG_BYPASS, 17'h1FFFE);
		set_reg(otms_pkg::REG_DRIVE_RANGE, 17'(otms_pkg::RANGE_MID));
		set_reg(otms_pkg::REG_DRIVE_KNOB, 17'h8000);
		set_reg(otms_pkg::REG_TONE_COEFF, 17'd65536);
		set_reg(otms_pkg::REG_OUTPUT_LEVEL, 17'hFFFF);
		set_reg(otms_pkg::REG_WET_MIX, 17'h8000);
		send_frame('1, SB'(1));
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		send_frame(SB'(2047), SB'(-2048));
		drain();
		set_reg(otms_pkg::REG_DRIVE_RANGE, 17'(otms_pkg::RANGE_HIGH));
		set_reg(otms_pkg::REG_DRIVE_KNOB, 17'h4000);
		send_frame(SB'(300000), SB'(-300000));
		send_frame(draw_sample(), draw_sample());
		drain();
	endtask

	// The result side stops taking results for a long stretch while frames
	// keep coming back to back, so the core fills up and holds its input.
	task automatic test_output_hold_off();
		set_reg(otms_pkg::REG_BYPASS, 17'd0);
		in_gap_max = 0;
		hold_off_request = HOLD_OFF_CYCLES;
		repeat (12) send_frame(draw_sample(), draw_sample());
		drain();
		in_gap_max = WAIT_MAX;
	endtask

	// Random settings, each followed by a burst of random frames. Upper data
	// bits of the narrow registers are filled with junk to check masking.
	task automatic test_random_settings();
		logic pass_through;
		for (int s = 0; s < SETTINGS_RUN; s++) begin
			drain();
			pass_through = ($urandom_range(0, 5) == 0);
			set_reg(otms_pkg::REG_BYPASS, {16'($urandom), pass_through});
			set_reg(otms_pkg::REG_DRIVE_RANGE, 17'($urandom));
			set_reg(otms_pkg::REG_DRIVE_KNOB, {1'($urandom), draw_fraction()});
			set_reg(otms_pkg::REG_BOOST_HELD, 17'($urandom));
			set_reg(otms_pkg::REG_TONE_COEFF, draw_tone());
			set_reg(otms_pkg::REG_OUTPUT_LEVEL, {1'($urandom), draw_fraction()});
			set_reg(otms_pkg::REG_WET_MIX, {1'($urandom), draw_fraction()});
			in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : WAIT_MAX;
			out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : WAIT_MAX;
			settings_run++;
			repeat (FRAMES_PER_SETTING) send_frame(draw_sample(), draw_sample());
		end
		drain();
	endtask

	// Result side: a random stall per result, or the long hold-off when the
	// back-pressure test asks for it, then wait for the core's valid.
	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_request > 0) begin
				stall = hold_off_request;
				hold_off_request = 0;
			end else begin
				stall = draw_wait(out_gap_max);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			check_frame(left_out, right_out);
		end
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		// Shadow registers and filter memories start at the core's reset values.
		m_bypass = 1'b1;
		m_range = otms_pkg::RANGE_LOW;
		m_knob = 16'd0;
		m_boost = 1'b0;
		m_tone = 17'd65536;
		m_level = 16'hFFFF;
		m_mix = 16'hFFFF;
		tone_mem = '{0, 0};
		dc_mem = '{0, 0};
		in_gap_max = WAIT_MAX;
		out_gap_max = WAIT_MAX;
		hold_off_request = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bypass_after_reset();
		test_reset_defaults();
		test_hard_drive();
		test_dry_frozen_tone();
		test_bypass_keeps_state();
		test_output_hold_off();
		test_random_settings();

		// Any stray result would show up in the checker during this tail.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_frames.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_frames.size());
			failures++;
		end
		$display("Sent %0d frames (%0d results checked) under %0d random settings.",
			frames_sent, frames_checked, settings_run);
		$display("Covered bypass, all drive ranges, boost, tone and mix extremes, hold-off.");
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
